>>> rtl/pvd_pkg.sv
// ---------------------------------------------------------------------------
// pvd_pkg
// Shared widths, mode codes and queue entry types for the pairwise vector
// distance block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pvd_pkg;

   // element format after conversion, signed Q1.15
   localparam int Q_W   = 16;
   localparam int LNX_W = Q_W - 1;

   // distance mode codes
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_KL    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COS   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EUC   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESET = MODE_COS;

   // accumulation
   localparam int ACC_W  = 48;
   localparam int DQ_W   = Q_W + 1;
   localparam int LN_W   = 21;
   localparam int TERM_W = DQ_W + LN_W;

   // log unit
   localparam int EXP_W   = 4;
   localparam int MANT_W  = 31;
   localparam int FRAC_W  = 16;
   localparam int LNP_W   = LN_W + 17;
   localparam logic [15:0] LN2_Q16 = 16'd45426;

   // result
   localparam int OUT_W     = 32;
   localparam int COS_SHIFT = 14;
   localparam int COS_W     = ACC_W - COS_SHIFT + 2;
   localparam int COS_ONE   = 65536;
   localparam int ROOT_W    = 25;
   localparam int SQ_IN_W   = 2 * ROOT_W;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [Q_W-1:0]    q;
      logic [Q_W-1:0]    t;
      logic [MODE_W-1:0] mode;
      logic              add_term;
      logic              last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

>>> rtl/pvd_if.sv
// ---------------------------------------------------------------------------
// pvd_if
// Valid/ready channels of the distance block: request, response and the
// mode register write port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pvd_req_if #(parameter int ELEM_BITS = 16);
   logic                        valid;
   logic                        ready;
   logic signed [ELEM_BITS-1:0] query_elem;
   logic signed [ELEM_BITS-1:0] test_elem;
   logic                        last_elem;

   modport source (output valid, query_elem, test_elem, last_elem, input ready);
   modport sink   (input valid, query_elem, test_elem, last_elem, output ready);
endinterface

interface pvd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [pvd_pkg::OUT_W-1:0] distance;
   logic                             saturated;

   modport source (output valid, distance, saturated, input ready);
   modport sink   (input valid, distance, saturated, output ready);
endinterface

interface pvd_csr_if;
   logic                        valid;
   logic                        ready;
   logic [pvd_pkg::MODE_W-1:0]  distance_mode;

   modport source (output valid, distance_mode, input ready);
   modport sink   (input valid, distance_mode, output ready);
endinterface

>>> rtl/pvd_fifo.sv
// ---------------------------------------------------------------------------
// pvd_fifo
// Short register queue between the front end and the arithmetic back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [WIDTH-1:0]   wr_data,
   input  logic               pop,
   output logic [WIDTH-1:0]   rd_data,
   output pvd_pkg::qstat_type stat
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data    = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

>>> rtl/pvd_ln.sv
// ---------------------------------------------------------------------------
// pvd_ln
// Iterative natural log of x / 2^15 in Q.16: leading-one exponent, sixteen
// mantissa squarings, then one scale by ln2.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvd_ln (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [pvd_pkg::LNX_W-1:0]         x,
   output logic                              done,
   output logic signed [pvd_pkg::LN_W-1:0]   ln
);
   localparam int CNT_W = $clog2(pvd_pkg::FRAC_W + 1);

   logic                              busy_ff, busy_in;
   logic                              scale_ff, scale_in;
   logic                              done_ff, done_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic [pvd_pkg::EXP_W-1:0]         exp_ff, exp_in, lead;
   logic [pvd_pkg::MANT_W-1:0]        mant_ff, mant_in, mant_init;
   logic [pvd_pkg::FRAC_W-1:0]        frac_ff, frac_in;
   logic [2*pvd_pkg::MANT_W-1:0]      sq;
   logic [pvd_pkg::MANT_W:0]          sq_top;
   logic [pvd_pkg::EXP_W:0]           exp_rel;
   logic signed [pvd_pkg::LN_W-1:0]   l2;
   logic signed [pvd_pkg::LNP_W-1:0]  prod_ff, prod_in;

   // leading one gives the integer part of log2
   always_comb begin
      lead = '0;
      for (int i = 0; i < pvd_pkg::LNX_W; i++) begin
         if (x[i]) begin
            lead = pvd_pkg::EXP_W'(i);
         end
      end
   end

   assign mant_init = pvd_pkg::MANT_W'(x)
                      << ((pvd_pkg::EXP_W + 1)'(pvd_pkg::MANT_W - 1) - {1'b0, lead});
   assign sq        = mant_ff * mant_ff;
   assign sq_top    = sq[2*pvd_pkg::MANT_W-1 -: pvd_pkg::MANT_W+1];
   assign exp_rel   = {1'b0, exp_ff} - (pvd_pkg::EXP_W + 1)'(pvd_pkg::LNX_W);
   assign l2        = {exp_rel, frac_ff};
   assign prod_in   = pvd_pkg::LNP_W'(l2)
                      * pvd_pkg::LNP_W'($signed({1'b0, pvd_pkg::LN2_Q16}));

   always_comb begin
      busy_in  = busy_ff;
      scale_in = 1'b0;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      exp_in   = exp_ff;
      mant_in  = mant_ff;
      frac_in  = frac_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         exp_in  = lead;
         mant_in = mant_init;
         frac_in = '0;
      end else if (busy_ff) begin
         // square stays in [1,4); renormalize and emit one fraction bit
         mant_in = sq_top[pvd_pkg::MANT_W] ? sq_top[pvd_pkg::MANT_W:1]
                                           : sq_top[pvd_pkg::MANT_W-1:0];
         frac_in = {frac_ff[pvd_pkg::FRAC_W-2:0], sq_top[pvd_pkg::MANT_W]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(pvd_pkg::FRAC_W - 1)) begin
            busy_in  = 1'b0;
            scale_in = 1'b1;
         end
      end else if (scale_ff) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         scale_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         scale_ff <= scale_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      exp_ff  <= exp_in;
      mant_ff <= mant_in;
      frac_ff <= frac_in;
      if (scale_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign done = done_ff;
   assign ln   = prod_ff[pvd_pkg::LN_W+pvd_pkg::FRAC_W-1:pvd_pkg::FRAC_W];

endmodule

>>> rtl/pvd_isqrt.sv
// ---------------------------------------------------------------------------
// pvd_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvd_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pvd_pkg::SQ_IN_W-1:0]  radicand,
   output logic                         done,
   output logic [pvd_pkg::ROOT_W-1:0]   root
);
   localparam int CNT_W = $clog2(pvd_pkg::ROOT_W + 1);
   localparam int REM_W = pvd_pkg::ROOT_W + 3;

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [pvd_pkg::SQ_IN_W-1:0]  val_ff, val_in;
   logic [REM_W-1:0]             rem_ff, rem_in, rem_sh, trial;
   logic [pvd_pkg::ROOT_W-1:0]   root_ff, root_in;

   assign rem_sh = {rem_ff[REM_W-3:0], val_ff[pvd_pkg::SQ_IN_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in = {val_ff[pvd_pkg::SQ_IN_W-3:0], 2'b00};
         cnt_in = cnt_ff + 1'b1;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[pvd_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[pvd_pkg::ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(pvd_pkg::ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> rtl/pvd_front.sv
// ---------------------------------------------------------------------------
// pvd_front
// Takes requests, converts elements to Q1.15, holds the mode register and
// the element count, and tags each entry for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvd_front #(
   parameter int MAX_DIM   = 256,
   parameter int ELEM_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   pvd_req_if.sink            req_ch,
   pvd_csr_if.sink            csr_ch,
   input  pvd_pkg::qstat_type qstat,
   output logic               push,
   output pvd_pkg::entry_type entry
);
   localparam int CNT_W = $clog2(MAX_DIM + 1);

   logic [pvd_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [pvd_pkg::Q_W-1:0]    q15, t15;
   logic                       add_term;

   generate
      if (ELEM_BITS >= pvd_pkg::Q_W) begin : g_narrow
         // floor shift down to Q1.15 keeps the top bits
         assign q15 = req_ch.query_elem[ELEM_BITS-1 -: pvd_pkg::Q_W];
         assign t15 = req_ch.test_elem[ELEM_BITS-1 -: pvd_pkg::Q_W];
      end else begin : g_widen
         assign q15 = {req_ch.query_elem, {(pvd_pkg::Q_W - ELEM_BITS){1'b0}}};
         assign t15 = {req_ch.test_elem, {(pvd_pkg::Q_W - ELEM_BITS){1'b0}}};
      end
   endgenerate

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !qstat.full;
   assign push         = req_ch.valid && req_ch.ready;

   // elements past the maximum dimension add no term
   assign add_term = (count_ff < CNT_W'(MAX_DIM));

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         mode_in = csr_ch.distance_mode;
      end
      if (push) begin
         if (req_ch.last_elem) begin
            count_in = '0;
         end else if (add_term) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= pvd_pkg::MODE_RESET;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   assign entry.q        = q15;
   assign entry.t        = t15;
   assign entry.mode     = mode_ff;
   assign entry.add_term = add_term;
   assign entry.last     = req_ch.last_elem;

endmodule

>>> rtl/pvd_back.sv
// ---------------------------------------------------------------------------
// pvd_back
// Pops queue entries, forms the per-element term, accumulates with
// saturation and finishes the distance at the frame end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvd_back (
   input  logic               clock,
   input  logic               reset,
   input  pvd_pkg::qstat_type qstat,
   input  pvd_pkg::entry_type head,
   output logic               pop,
   pvd_rsp_if.source          rsp_ch
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LN   = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_ACC  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;
   localparam logic [2:0] S_SQRT = 3'd5;
   localparam logic [2:0] S_EMIT = 3'd6;

   localparam int SH_W  = pvd_pkg::ACC_W - pvd_pkg::COS_SHIFT;
   localparam int TOP_W = pvd_pkg::COS_W - pvd_pkg::OUT_W + 1;

   // non-positive elements clamp to the smallest positive value
   function automatic logic [pvd_pkg::LNX_W-1:0] clamp_pos(
      input logic [pvd_pkg::Q_W-1:0] v
   );
      logic pos;
      pos = !v[pvd_pkg::Q_W-1] && (|v[pvd_pkg::Q_W-2:0]);
      return pos ? v[pvd_pkg::Q_W-2:0] : pvd_pkg::LNX_W'(1);
   endfunction

   logic [2:0]                         state_ff, state_in;
   pvd_pkg::entry_type                 cur_ff, cur_in;
   logic signed [pvd_pkg::LN_W-1:0]    lndiff_ff, lndiff_in;
   logic signed [pvd_pkg::TERM_W-1:0]  term_ff, term_in;
   logic [pvd_pkg::ACC_W-1:0]          sum_ff, sum_in;
   logic [pvd_pkg::OUT_W-1:0]          res_dist_ff, res_dist_in;
   logic                               res_sat_ff, res_sat_in;
   logic                               out_valid_ff, out_valid_in;
   logic [pvd_pkg::OUT_W-1:0]          out_dist_ff, out_dist_in;
   logic                               out_sat_ff, out_sat_in;

   logic                               ln_start;
   logic                               ln_q_done, ln_t_done;
   logic signed [pvd_pkg::LN_W-1:0]    ln_q_val, ln_t_val;
   logic                               sq_start, sq_done;
   logic [pvd_pkg::SQ_IN_W-1:0]        sq_radicand;
   logic [pvd_pkg::ROOT_W-1:0]         sq_root;

   logic [pvd_pkg::LNX_W-1:0]          qc, tc;
   logic [pvd_pkg::DQ_W-1:0]           diff;
   logic signed [pvd_pkg::DQ_W-1:0]    mul_a;
   logic signed [pvd_pkg::LN_W-1:0]    mul_b;
   logic signed [pvd_pkg::TERM_W-1:0]  mul_p;
   logic [pvd_pkg::ACC_W:0]            sum_wide;
   logic [pvd_pkg::ACC_W-1:0]          sum_sat;
   logic [SH_W-1:0]                    cos_sh;
   logic [pvd_pkg::COS_W-1:0]          cos_v;
   logic [TOP_W-1:0]                   cos_top;
   logic                               cos_ovf;
   logic [pvd_pkg::OUT_W-1:0]          cos_res;

   assign ln_start = pop && (head.mode == pvd_pkg::MODE_KL) && head.add_term;

   pvd_ln u_ln_q (
      .clock (clock),
      .reset (reset),
      .start (ln_start),
      .x     (clamp_pos(head.q)),
      .done  (ln_q_done),
      .ln    (ln_q_val)
   );

   pvd_ln u_ln_t (
      .clock (clock),
      .reset (reset),
      .start (ln_start),
      .x     (clamp_pos(head.t)),
      .done  (ln_t_done),
      .ln    (ln_t_val)
   );

   assign sq_start    = (state_ff == S_FIN) && (cur_ff.mode == pvd_pkg::MODE_EUC);
   assign sq_radicand = sum_ff[pvd_pkg::ACC_W-1] ? '0
                        : pvd_pkg::SQ_IN_W'({sum_ff[pvd_pkg::ACC_W-2:0], 2'b00});

   pvd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_radicand),
      .done     (sq_done),
      .root     (sq_root)
   );

   // one shared multiplier for all three term kinds
   always_comb begin
      qc    = clamp_pos(cur_ff.q);
      tc    = clamp_pos(cur_ff.t);
      diff  = {cur_ff.q[pvd_pkg::Q_W-1], cur_ff.q} - {cur_ff.t[pvd_pkg::Q_W-1], cur_ff.t};
      mul_a = '0;
      mul_b = '0;
      if (cur_ff.add_term) begin
         unique case (cur_ff.mode)
            pvd_pkg::MODE_KL: begin
               mul_a = {2'b00, qc} - {2'b00, tc};
               mul_b = lndiff_ff;
            end
            pvd_pkg::MODE_COS: begin
               mul_a = {cur_ff.q[pvd_pkg::Q_W-1], cur_ff.q};
               mul_b = {{(pvd_pkg::LN_W - pvd_pkg::Q_W){cur_ff.t[pvd_pkg::Q_W-1]}},
                        cur_ff.t};
            end
            pvd_pkg::MODE_EUC: begin
               mul_a = diff;
               mul_b = {{(pvd_pkg::LN_W - pvd_pkg::DQ_W){diff[pvd_pkg::DQ_W-1]}}, diff};
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   assign mul_p = pvd_pkg::TERM_W'(mul_a) * pvd_pkg::TERM_W'(mul_b);

   // saturating accumulate
   assign sum_wide = {sum_ff[pvd_pkg::ACC_W-1], sum_ff}
                     + {{(pvd_pkg::ACC_W + 1 - pvd_pkg::TERM_W){term_ff[pvd_pkg::TERM_W-1]}},
                        term_ff};
   assign sum_sat  = (sum_wide[pvd_pkg::ACC_W] != sum_wide[pvd_pkg::ACC_W-1])
                     ? {sum_wide[pvd_pkg::ACC_W], {(pvd_pkg::ACC_W-1){~sum_wide[pvd_pkg::ACC_W]}}}
                     : sum_wide[pvd_pkg::ACC_W-1:0];

   // cosine: one minus the dot product, clipped to 32 bits
   assign cos_sh  = sum_ff[pvd_pkg::ACC_W-1:pvd_pkg::COS_SHIFT];
   assign cos_v   = pvd_pkg::COS_W'(pvd_pkg::COS_ONE) - {{2{cos_sh[SH_W-1]}}, cos_sh};
   assign cos_top = cos_v[pvd_pkg::COS_W-1:pvd_pkg::OUT_W-1];
   assign cos_ovf = !((&cos_top) || !(|cos_top));
   assign cos_res = cos_ovf
                    ? {cos_v[pvd_pkg::COS_W-1], {(pvd_pkg::OUT_W-1){~cos_v[pvd_pkg::COS_W-1]}}}
                    : cos_v[pvd_pkg::OUT_W-1:0];

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      lndiff_in    = lndiff_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      res_dist_in  = res_dist_ff;
      res_sat_in   = res_sat_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_dist_in  = out_dist_ff;
      out_sat_in   = out_sat_ff;
      pop          = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!qstat.empty) begin
               pop    = 1'b1;
               cur_in = head;
               state_in = ((head.mode == pvd_pkg::MODE_KL) && head.add_term) ? S_LN : S_MUL;
            end
         end
         S_LN: begin
            if (ln_q_done && ln_t_done) begin
               lndiff_in = ln_q_val - ln_t_val;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            term_in  = mul_p;
            state_in = S_ACC;
         end
         S_ACC: begin
            sum_in   = sum_sat;
            state_in = cur_ff.last ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            sum_in     = '0;
            res_sat_in = 1'b0;
            state_in   = S_EMIT;
            unique case (cur_ff.mode)
               pvd_pkg::MODE_KL: begin
                  // the 0.5 factor folds into the shift
                  res_dist_in = sum_ff[pvd_pkg::ACC_W-1 -: pvd_pkg::OUT_W];
               end
               pvd_pkg::MODE_COS: begin
                  res_dist_in = cos_res;
                  res_sat_in  = cos_ovf;
               end
               pvd_pkg::MODE_EUC: begin
                  state_in = S_SQRT;
               end
               default: begin
                  res_dist_in = '0;
               end
            endcase
         end
         S_SQRT: begin
            if (sq_done) begin
               res_dist_in = pvd_pkg::OUT_W'(sq_root);
               state_in    = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in = 1'b1;
               out_dist_in  = res_dist_ff;
               out_sat_in   = res_sat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      lndiff_ff   <= lndiff_in;
      term_ff     <= term_in;
      res_dist_ff <= res_dist_in;
      res_sat_ff  <= res_sat_in;
      out_dist_ff <= out_dist_in;
      out_sat_ff  <= out_sat_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.distance  = out_dist_ff;
   assign rsp_ch.saturated = out_sat_ff;

endmodule

>>> rtl/pairwise_vector_distance_top.sv
// ---------------------------------------------------------------------------
// pairwise_vector_distance_top
// Requests enter a four-entry queue at one per cycle while it has room.
// The back end steps each element through pop, multiply and accumulate
// states before popping the next, and KL waits in a log state for the
// sixteen squarings of the iterative log units. A frame result takes the
// finish and emit states, with the one-bit-per-cycle square root between for euclidean.
// Synchronous reset clears the queue, the running sum, the element count and
// sets the mode to cosine; no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pairwise_vector_distance_top #(
   parameter int MAX_DIM   = 256,
   parameter int ELEM_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   pvd_req_if.sink    req_ch,
   pvd_rsp_if.source  rsp_ch,
   pvd_csr_if.sink    csr_ch
);
   localparam int ENTRY_W = $bits(pvd_pkg::entry_type);

   logic               push;
   logic               pop;
   pvd_pkg::qstat_type qstat;
   pvd_pkg::entry_type entry;
   pvd_pkg::entry_type head;
   logic [ENTRY_W-1:0] head_bits;

   pvd_front #(
      .MAX_DIM   (MAX_DIM),
      .ELEM_BITS (ELEM_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .qstat  (qstat),
      .push   (push),
      .entry  (entry)
   );

   pvd_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (pvd_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (entry),
      .pop     (pop),
      .rd_data (head_bits),
      .stat    (qstat)
   );

   assign head = pvd_pkg::entry_type'(head_bits);

   pvd_back u_back (
      .clock  (clock),
      .reset  (reset),
      .qstat  (qstat),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("queue reports full and empty together");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push |=> !qstat.empty)
      else $error("queue empty right after a request was pushed");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("back end popped an empty queue");

   a_sat_clip: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.saturated) |->
      (rsp_ch.distance == 32'sh7fffffff || rsp_ch.distance == 32'sh80000000))
      else $error("saturated result is not a range limit");

endmodule

>>> tb/sv/pairwise_vector_distance_top_tb.sv
// ---------------------------------------------------------------------------
// pairwise_vector_distance_top_tb
// Streams paired frame elements through the distance block in every mode,
// predicts each frame distance in a scoreboard and compares every response
// field by field. Covers field extremes, clamping of non-positive KL inputs,
// the undefined mode, mode changes inside an open frame and a frame past
// MAX_DIM, under random idling on both channels and a long response stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
   logic signed [31:0] distance;
   logic               saturated;
} distance_result_type;

class distance_board_type;
   localparam int     FRAME_MAX = 256;
   localparam longint SUM_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_MIN   = -SUM_MAX - 1;

   logic [1:0]          mode;
   longint              frame_sum;
   int                  frame_elems;
   distance_result_type expected_distances[$];
   int                  errors;
   int                  results_checked;

   function new();
      mode            = pvd_pkg::MODE_RESET;
      frame_sum       = 0;
      frame_elems     = 0;
      errors          = 0;
      results_checked = 0;
   endfunction

   function void set_mode(logic [1:0] m);
      mode = m;
   endfunction

   // natural log of x / 2^15 in Q.16, log2 by repeated squaring
   function longint ln_q16(int unsigned x);
      int unsigned       e;
      int unsigned       frac;
      longint unsigned   m;
      longint            l2;
      longint            ee;
      e    = 0;
      frac = 0;
      while (e < 14 && (x >> (e + 1)) != 0)
         e++;
      m = x;
      m = m << (30 - e);
      for (int i = 0; i < 16; i++) begin
         m    = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m    = m >> 1;
            frac = frac | 1;
         end
      end
      ee = e;
      l2 = (ee - 15) * 65536 + longint'(frac);
      return (l2 * longint'(pvd_pkg::LN2_Q16)) >>> 16;
   endfunction

   function void note_request(logic signed [15:0] q_in, logic signed [15:0] t_in,
                              logic last);
      longint              q, t, qc, tc, term, v;
      longint unsigned     rem, root, probe;
      distance_result_type r;
      q    = q_in;
      t    = t_in;
      term = 0;
      if (frame_elems < FRAME_MAX) begin
         frame_elems++;
         case (mode)
            pvd_pkg::MODE_KL: begin
               qc   = (q > 0) ? q : 1;
               tc   = (t > 0) ? t : 1;
               term = (qc - tc) * (ln_q16(32'(qc)) - ln_q16(32'(tc)));
            end
            pvd_pkg::MODE_COS: term = q * t;
            pvd_pkg::MODE_EUC: term = (q - t) * (q - t);
            default:           term = 0;
         endcase
         frame_sum = frame_sum + term;
         if (frame_sum > SUM_MAX) frame_sum = SUM_MAX;
         if (frame_sum < SUM_MIN) frame_sum = SUM_MIN;
      end
      if (!last)
         return;
      v = 0;
      case (mode)
         pvd_pkg::MODE_KL:  v = frame_sum >>> 16;
         pvd_pkg::MODE_COS: v = 65536 - (frame_sum >>> 14);
         pvd_pkg::MODE_EUC: begin
            rem   = (frame_sum > 0) ? frame_sum : 0;
            rem   = rem * 4;
            root  = 0;
            probe = 64'd1 << 62;
            while (probe > rem)
               probe = probe >> 2;
            while (probe != 0) begin
               if (rem >= root + probe) begin
                  rem  = rem - (root + probe);
                  root = (root >> 1) + probe;
               end else begin
                  root = root >> 1;
               end
               probe = probe >> 2;
            end
            v = root;
         end
         default: v = 0;
      endcase
      r.saturated = 1'b0;
      if (v > 64'sd2147483647) begin
         v           = 64'sd2147483647;
         r.saturated = 1'b1;
      end else if (v < -64'sd2147483648) begin
         v           = -64'sd2147483648;
         r.saturated = 1'b1;
      end
      r.distance = v[31:0];
      expected_distances.push_back(r);
      frame_sum   = 0;
      frame_elems = 0;
   endfunction

   function void check_result(logic signed [31:0] distance, logic saturated);
      distance_result_type exp_r;
      if (expected_distances.size() == 0) begin
         $error("response with no distance pending: distance %0d saturated %0b",
                distance, saturated);
         errors++;
         return;
      end
      exp_r = expected_distances.pop_front();
      results_checked++;
      if (distance !== exp_r.distance) begin
         $error("distance: expected %0d, actual %0d", exp_r.distance, distance);
         errors++;
      end
      if (saturated !== exp_r.saturated) begin
         $error("saturated: expected %0b, actual %0b", exp_r.saturated, saturated);
         errors++;
      end
   endfunction
endclass

module pairwise_vector_distance_top_tb;
   localparam int         FRAME_MAX    = 256;
   localparam int         TARGET_REQS  = 600;
   localparam int         SETTLE_WAIT  = 200;
   localparam logic [1:0] MODE_UNDEF   = 2'd3;

   logic clock = 1'b0;
   logic reset;

   pvd_req_if #(.ELEM_BITS(16)) req_ch();
   pvd_rsp_if                   rsp_ch();
   pvd_csr_if                   csr_ch();

   pairwise_vector_distance_top #(
      .MAX_DIM  (FRAME_MAX),
      .ELEM_BITS(16)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   distance_board_type board = new();

   int send_idle_pct = 0;
   int take_idle_pct = 0;
   int rsp_hold_left = 0;
   int requests_sent = 0;
   int mode_writes   = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // response side: random back-pressure plus an optional long hold
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ch.ready  = 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_ch.ready = ($urandom_range(99) >= take_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_result(rsp_ch.distance, rsp_ch.saturated);
   end

   task automatic send_elem(input logic signed [15:0] q, input logic signed [15:0] t,
                            input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_ch.valid      = 1'b1;
      req_ch.query_elem = q;
      req_ch.test_elem  = t;
      req_ch.last_elem  = last;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(q, t, last);
      requests_sent++;
      @(negedge clock);
   endtask

   // sender stops until every pending distance is back, then lets the
   // back end finish any open-frame elements
   task automatic settle();
      req_ch.valid = 1'b0;
      while (board.expected_distances.size() != 0)
         @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   task automatic write_mode(input logic [1:0] m);
      csr_ch.valid         = 1'b1;
      csr_ch.distance_mode = m;
      do @(posedge clock); while (!csr_ch.ready);
      board.set_mode(m);
      mode_writes++;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   function automatic logic signed [15:0] pick_elem();
      int sel;
      sel = $urandom_range(99);
      if (sel < 6)  return 16'sh8000;
      if (sel < 12) return 16'sh7FFF;
      if (sel < 16) return 16'sd0;
      if (sel < 20) return 16'sd1;
      if (sel < 24) return -16'sd1;
      if (sel < 34) return 16'($urandom_range(1, 64));
      return 16'($urandom);
   endfunction

   function automatic logic [1:0] pick_mode();
      int sel;
      sel = $urandom_range(9);
      if (sel < 3) return pvd_pkg::MODE_KL;
      if (sel < 6) return pvd_pkg::MODE_COS;
      if (sel < 9) return pvd_pkg::MODE_EUC;
      return MODE_UNDEF;
   endfunction

   initial begin
      int  frames, len;
      bit  pressure_done, long_done;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.query_elem    = '0;
      req_ch.test_elem     = '0;
      req_ch.last_elem     = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.distance_mode = pvd_pkg::MODE_RESET;
      pressure_done        = 1'b0;
      long_done            = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // cosine is the reset mode
      send_elem(16'sh7FFF, 16'sh7FFF, 1'b1);
      send_elem(16'sh8000, 16'sh8000, 1'b1);
      send_elem(16'sh8000, 16'sh7FFF, 1'b0);
      send_elem(16'sd0, 16'sd0, 1'b1);
      settle();
      write_mode(pvd_pkg::MODE_KL);
      send_elem(16'sh7FFF, 16'sd1, 1'b1);
      send_elem(16'sh8000, 16'sd5, 1'b1);      // non-positive query clamps to smallest value
      send_elem(16'sd0, 16'sd0, 1'b0);
      send_elem(16'sd1, 16'sh7FFF, 1'b0);
      send_elem(-16'sd1, 16'sd16384, 1'b1);
      settle();
      write_mode(pvd_pkg::MODE_EUC);
      send_elem(16'sh7FFF, 16'sh8000, 1'b1);
      send_elem(16'sh8000, 16'sh7FFF, 1'b0);
      send_elem(16'sd0, 16'sd0, 1'b0);
      send_elem(16'sd12345, 16'sd12344, 1'b1);
      settle();
      write_mode(MODE_UNDEF);
      send_elem(16'sd12345, -16'sd5, 1'b0);
      send_elem(16'sh7FFF, 16'sh7FFF, 1'b1);
      // frame closed here; the mode writes after the next one switch with a frame still open
      settle();
      write_mode(pvd_pkg::MODE_EUC);
      send_elem(16'sd1000, -16'sd1000, 1'b0);
      settle();
      write_mode(pvd_pkg::MODE_COS);
      send_elem(16'sd2000, 16'sd3000, 1'b0);
      settle();
      write_mode(pvd_pkg::MODE_KL);
      send_elem(16'sd100, 16'sd20000, 1'b1);

      while (requests_sent < TARGET_REQS) begin
         if (requests_sent < 200) begin
            send_idle_pct = 26;
            take_idle_pct = 59;
         end else if (requests_sent < 400) begin
            send_idle_pct = 59;
            take_idle_pct = 26;
         end else begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end
         settle();
         write_mode(pick_mode());
         if (!pressure_done && requests_sent >= 400) begin
            // hold responses off long enough for the request queue to back up
            pressure_done = 1'b1;
            rsp_hold_left = 400;
            repeat (40) send_elem(pick_elem(), pick_elem(), 1'b1);
         end else if (!long_done && requests_sent >= 200) begin
            long_done = 1'b1;
            for (int i = 0; i < FRAME_MAX + 2; i++)
               send_elem(pick_elem(), pick_elem(), i == FRAME_MAX + 1);
         end else begin
            frames = $urandom_range(3, 8);
            repeat (frames) begin
               len = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
               for (int i = 0; i < len; i++)
                  send_elem(pick_elem(), pick_elem(), i == len - 1);
            end
            // sometimes leave a frame open across the next mode write
            if ($urandom_range(3) == 0)
               repeat ($urandom_range(1, 3)) send_elem(pick_elem(), pick_elem(), 1'b0);
         end
      end
      // close any open frame before the end
      send_elem(pick_elem(), pick_elem(), 1'b1);
      settle();

      while (board.expected_distances.size() != 0) begin
         void'(board.expected_distances.pop_front());
         $error("distance expected but never returned");
         board.errors++;
      end
      $display("summary: %0d requests, %0d distances checked, %0d mode writes",
               requests_sent, board.results_checked, mode_writes);
      $display("summary: all mode codes, clamped KL inputs, open-frame mode changes,");
      $display("         a frame past MAX_DIM and a long response stall");
      if (board.errors == 0) begin
         $display("pairwise_vector_distance_top_tb: done, clean");
      end else begin
         $display("pairwise_vector_distance_top_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("pairwise_vector_distance_top_tb: done, errors");
      $finish;
   end
endmodule
